### rtl/vfc_pkg.sv
// Package for the voxel face cull and occlusion block: constants, face tables, record types.
`default_nettype none

package vfc_pkg;

    localparam int NUM_FACES   = 6;
    localparam int NUM_CORNERS = 4;
    localparam int MAP_W       = 27;
    localparam int MAP_IDX_W   = 5;
    localparam int COORD_W     = 12;
    localparam int KIND_W      = 8;
    localparam int FACE_W      = 3;
    localparam int OCC_W       = 2;
    localparam int VERTEX_W    = 32;

    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [VERTEX_W-1:0] VERTS_PER_FACE = VERTEX_W'(4);
    localparam logic [OCC_W-1:0]    OCC_FULL       = OCC_W'(3);

    typedef enum logic [FACE_W-1:0] {
        FACE_FRONT  = 3'd0,
        FACE_BACK   = 3'd1,
        FACE_RIGHT  = 3'd2,
        FACE_LEFT   = 3'd3,
        FACE_TOP    = 3'd4,
        FACE_BOTTOM = 3'd5
    } face_id_t;

    // Map bit of the neighbor across each face.
    localparam logic [MAP_IDX_W-1:0] NORMAL_BIT [NUM_FACES] = '{22, 4, 14, 12, 16, 10};

    // Per face and corner: map bits of edge a, edge b and the diagonal.
    localparam logic [MAP_IDX_W-1:0] CORNER_BIT [NUM_FACES][NUM_CORNERS][3] = '{
        '{'{21, 19, 18}, '{23, 19, 20}, '{23, 25, 26}, '{21, 25, 24}},
        '{'{ 5,  1,  2}, '{ 3,  1,  0}, '{ 3,  7,  6}, '{ 5,  7,  8}},
        '{'{23, 11, 20}, '{ 5, 11,  2}, '{ 5, 17,  8}, '{23, 17, 26}},
        '{'{ 3,  9,  0}, '{21,  9, 18}, '{21, 15, 24}, '{ 3, 15,  6}},
        '{'{15, 25, 24}, '{17, 25, 26}, '{17,  7,  8}, '{15,  7,  6}},
        '{'{ 9,  1,  0}, '{11,  1,  2}, '{11, 19, 20}, '{ 9, 19, 18}}
    };

    typedef logic [NUM_CORNERS-1:0][OCC_W-1:0] face_occ_t;

    typedef struct packed {
        logic                             chunk_start;
        logic [KIND_W-1:0]                kind;
        logic [NUM_FACES-1:0]             vis;
        logic [NUM_FACES-1:0][NUM_CORNERS-1:0][OCC_W-1:0] occ;
    } face_rec_t;

    function automatic logic [OCC_W-1:0] occ_level(
        input logic [MAP_W-1:0]     map,
        input logic [MAP_IDX_W-1:0] ia,
        input logic [MAP_IDX_W-1:0] ib,
        input logic [MAP_IDX_W-1:0] ic
    );
        logic sa;
        logic sb;
        logic sc;
        sa = map[ia];
        sb = map[ib];
        sc = map[ic];
        if (sa && sb)
        begin
            return OCC_FULL;
        end
        return {1'b0, sa} + {1'b0, sb} + {1'b0, sc};
    endfunction

endpackage

`default_nettype wire

### rtl/vfc_ifs.sv
// Channel interfaces: block items in, face items out.
`default_nettype none

interface vfc_in_if import vfc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MAP_W-1:0]   neighbor_opaque;
    logic [COORD_W-1:0] world_x;
    logic [COORD_W-1:0] world_y;
    logic [COORD_W-1:0] world_z;
    logic [KIND_W-1:0]  block_kind;
    logic               chunk_start;

    modport source (
        output valid, neighbor_opaque, world_x, world_y, world_z, block_kind, chunk_start,
        input  ready
    );
    modport sink (
        input  valid, neighbor_opaque, world_x, world_y, world_z, block_kind, chunk_start,
        output ready
    );
endinterface

interface vfc_out_if import vfc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FACE_W-1:0]   face_id;
    logic [OCC_W-1:0]    occ_corner0;
    logic [OCC_W-1:0]    occ_corner1;
    logic [OCC_W-1:0]    occ_corner2;
    logic [OCC_W-1:0]    occ_corner3;
    logic [VERTEX_W-1:0] base_vertex;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [COORD_W-1:0]  out_z;
    logic [KIND_W-1:0]   out_kind;
    logic                last_face;

    modport source (
        output valid, face_id, occ_corner0, occ_corner1, occ_corner2, occ_corner3,
               base_vertex, out_x, out_y, out_z, out_kind, last_face,
        input  ready
    );
    modport sink (
        input  valid, face_id, occ_corner0, occ_corner1, occ_corner2, occ_corner3,
               base_vertex, out_x, out_y, out_z, out_kind, last_face,
        output ready
    );
endinterface

`default_nettype wire

### rtl/vfc_front.sv
// Front stage: accepts block items, finds visible faces and corner occlusion, registers the record.
`default_nettype none

module vfc_front
    import vfc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vfc_in_if.sink      blocks,
    output logic        rec_valid,
    input  wire logic   rec_ready,
    output face_rec_t   rec,
    output logic [3*((COORD_BITS < COORD_W) ? COORD_BITS : COORD_W)-1:0] rec_xyz
);

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    logic               valid_reg;
    face_rec_t          rec_reg;
    face_rec_t          rec_next;
    logic [3*CW-1:0]    xyz_reg;
    logic [3*CW-1:0]    xyz_next;
    logic               take;

    assign blocks.ready = !valid_reg || rec_ready;
    assign take         = blocks.valid && blocks.ready;

    always_comb
    begin
        rec_next.chunk_start = blocks.chunk_start;
        rec_next.kind        = blocks.block_kind;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            rec_next.vis[f] = !blocks.neighbor_opaque[NORMAL_BIT[f]];
            for (int c = 0; c < NUM_CORNERS; c++)
            begin
                rec_next.occ[f][c] = occ_level(blocks.neighbor_opaque, CORNER_BIT[f][c][0],
                                               CORNER_BIT[f][c][1], CORNER_BIT[f][c][2]);
            end
        end
        xyz_next = {blocks.world_z[CW-1:0], blocks.world_y[CW-1:0], blocks.world_x[CW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (blocks.ready)
        begin
            valid_reg <= blocks.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rec_reg <= rec_next;
            xyz_reg <= xyz_next;
        end
    end

    assign rec_valid = valid_reg;
    assign rec       = rec_reg;
    assign rec_xyz   = xyz_reg;

endmodule

`default_nettype wire

### rtl/vfc_queue.sv
// Small FIFO between the classify front and the face sequencer.
`default_nettype none

module vfc_queue
    import vfc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg < NW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[head_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            end
            if (pop)
            begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/vfc_back.sv
// Back stage: walks visible faces one per cycle unless stalled, numbers vertices, drives faces.
`default_nettype none

module vfc_back
    import vfc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    output logic            q_pop,
    input  wire face_rec_t  q_rec,
    input  wire logic [3*((COORD_BITS < COORD_W) ? COORD_BITS : COORD_W)-1:0] q_xyz,
    vfc_out_if.source       faces
);

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    logic                 cur_valid_reg;
    logic [NUM_FACES-1:0] rem_reg;
    logic [NUM_FACES-1:0] rem_next;
    face_occ_t            occ_reg [NUM_FACES];
    logic [KIND_W-1:0]    kind_reg;
    logic [3*CW-1:0]      xyz_reg;
    logic [VERTEX_W-1:0]  vcount_reg;

    logic                 out_valid_reg;
    logic [FACE_W-1:0]    out_face_reg;
    face_occ_t            out_occ_reg;
    logic [VERTEX_W-1:0]  out_base_reg;
    logic [3*CW-1:0]      out_xyz_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_last_reg;

    logic [FACE_W-1:0]    sel;
    logic                 emit;
    logic                 done;

    always_comb
    begin
        sel = FACE_W'(0);
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (rem_reg[f])
            begin
                sel = FACE_W'(f);
            end
        end
    end

    assign rem_next = rem_reg & ~(NUM_FACES'(1) << sel);
    assign emit     = cur_valid_reg && (!out_valid_reg || faces.ready);
    assign done     = !cur_valid_reg || (emit && (rem_next == '0));
    assign q_pop    = q_valid && done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= |q_rec.vis;
                rem_reg       <= q_rec.vis;
            end
            else if (emit)
            begin
                cur_valid_reg <= |rem_next;
                rem_reg       <= rem_next;
            end

            // chunk clear belongs to the incoming block, after the current face
            if (q_pop && q_rec.chunk_start)
            begin
                vcount_reg <= '0;
            end
            else if (emit)
            begin
                vcount_reg <= vcount_reg + VERTS_PER_FACE;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (faces.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int f = 0; f < NUM_FACES; f++)
            begin
                occ_reg[f] <= q_rec.occ[f];
            end
            kind_reg <= q_rec.kind;
            xyz_reg  <= q_xyz;
        end
        if (emit)
        begin
            out_face_reg <= sel;
            out_occ_reg  <= occ_reg[sel];
            out_base_reg <= vcount_reg;
            out_xyz_reg  <= xyz_reg;
            out_kind_reg <= kind_reg;
            out_last_reg <= (rem_next == '0);
        end
    end

    assign faces.valid       = out_valid_reg;
    assign faces.face_id     = out_face_reg;
    assign faces.occ_corner0 = out_occ_reg[0];
    assign faces.occ_corner1 = out_occ_reg[1];
    assign faces.occ_corner2 = out_occ_reg[2];
    assign faces.occ_corner3 = out_occ_reg[3];
    assign faces.base_vertex = out_base_reg;
    assign faces.out_x       = COORD_W'(out_xyz_reg[CW-1:0]);
    assign faces.out_y       = COORD_W'(out_xyz_reg[2*CW-1:CW]);
    assign faces.out_z       = COORD_W'(out_xyz_reg[3*CW-1:2*CW]);
    assign faces.out_kind    = out_kind_reg;
    assign faces.last_face   = out_last_reg;

endmodule

`default_nettype wire

### rtl/voxel_face_cull_and_ao.sv
// Top level of the voxel face cull and vertex occlusion block.
// Usage:
//   blocks: one item per solid cube (3x3x3 opacity map, coordinates, kind, chunk_start).
//   faces : one item per exposed face, in front, back, right, left, top, bottom order,
//           with four corner occlusion levels (0..3), base vertex index and block data.
//           last_face marks the final face of a block; a fully enclosed block yields none.
//   An accepted block passes the front record register, the queue and the sequencer state
//   before its first face is registered at the output. The face sequencer issues one face
//   per cycle unless faces.ready stalls it. A queue of QUEUE_DEPTH records sits in front
//   of the sequencer, so blocks keep being accepted while faces of earlier ones drain.
//   The vertex counter advances by 4 per face, wraps at 2^32 and is cleared by chunk_start
//   ahead of that block's faces.
//   Reset clears the vertex counter, the queue and all valid flags; no item is in flight.
//   When faces.ready is low the registered face holds; the sequencer, then the queue and
//   finally blocks.ready back up in turn.
//   Coordinates keep their low COORD_BITS bits (up to 12).
`default_nettype none

module voxel_face_cull_and_ao
    import vfc_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vfc_in_if.sink      blocks,
    vfc_out_if.source   faces
);

    localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int REC_W = $bits(face_rec_t);
    localparam int Q_W   = REC_W + 3 * CW;

    logic            front_valid;
    logic            front_ready;
    face_rec_t       front_rec;
    logic [3*CW-1:0] front_xyz;
    logic            q_valid;
    logic            q_pop;
    logic [Q_W-1:0]  q_data;
    face_rec_t       q_rec;
    logic [3*CW-1:0] q_xyz;

    vfc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .blocks    (blocks),
        .rec_valid (front_valid),
        .rec_ready (front_ready),
        .rec       (front_rec),
        .rec_xyz   (front_xyz)
    );

    vfc_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  ({front_rec, front_xyz}),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    assign q_rec = face_rec_t'(q_data[Q_W-1:3*CW]);
    assign q_xyz = q_data[3*CW-1:0];

    vfc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_rec   (q_rec),
        .q_xyz   (q_xyz),
        .faces   (faces)
    );

    // Track the previous face delivered within a block.
    logic                mon_mid_reg;
    logic [FACE_W-1:0]   mon_face_reg;
    logic [VERTEX_W-1:0] mon_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_mid_reg <= 1'b0;
        end
        else if (faces.valid && faces.ready)
        begin
            mon_mid_reg <= !faces.last_face;
        end
    end

    always_ff @(posedge clk)
    begin
        if (faces.valid && faces.ready)
        begin
            mon_face_reg <= faces.face_id;
            mon_base_reg <= faces.base_vertex;
        end
    end

    a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
        faces.valid && mon_mid_reg |-> faces.face_id > mon_face_reg)
        else $error("faces of one block out of order");

    a_vertex_step: assert property (@(posedge clk) disable iff (!rst_n)
        faces.valid && mon_mid_reg |-> faces.base_vertex == mon_base_reg + VERTS_PER_FACE)
        else $error("base vertex did not advance by one face");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_rec))
        else $error("front record lost while queue full");

endmodule

`default_nettype wire
